// ===== design/sbrm_pkg.sv =====
// shared types and constants for the spectral bloom recurring-minimum block
// used by sbrm_ctrl, sbrm_dp and the top level; no dependencies
package sbrm_pkg;

	localparam int PRI_CELLS   = 1024;
	localparam int SEC_CELLS   = 256;
	localparam int PRI_AW      = 10;
	localparam int SEC_AW      = 8;
	localparam int EST_W       = 8;
	localparam int LANE_W      = 2;
	localparam int MAX_LANES   = 4;
	localparam int HITS_W      = 3;

	localparam int DEF_PRIMARY_WIDTH   = 8;
	localparam int DEF_SECONDARY_WIDTH = 8;
	localparam int DEF_NUM_HASHES      = 4;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clr;
		logic p_re;
		logic p_we;
		logic s_re;
		logic s_we;
		logic p_acc;
		logic s_acc;
		logic lane_rst;
		logic lane_inc;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic lane_last;
		logic clr_last;
		logic single;
		logic smin_nz;
	} sts_t;

endpackage

// ===== design/sbrm_dp.sv =====
// datapath: request registers, both counter memories, minimum tracking, result register
// depends on sbrm_pkg
module sbrm_dp import sbrm_pkg::*; #(
	parameter int PRIMARY_WIDTH   = DEF_PRIMARY_WIDTH,
	parameter int SECONDARY_WIDTH = DEF_SECONDARY_WIDTH,
	parameter int NUM_HASHES      = DEF_NUM_HASHES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [1:0]        op,
	input  logic [PRI_AW-1:0] primary_index_0,
	input  logic [PRI_AW-1:0] primary_index_1,
	input  logic [PRI_AW-1:0] primary_index_2,
	input  logic [PRI_AW-1:0] primary_index_3,
	input  logic [SEC_AW-1:0] secondary_index_0,
	input  logic [SEC_AW-1:0] secondary_index_1,
	input  logic [SEC_AW-1:0] secondary_index_2,
	input  logic [SEC_AW-1:0] secondary_index_3,
	output logic [EST_W-1:0]  estimate,
	output logic              single_minimum
);

	localparam int LANES = (NUM_HASHES < MAX_LANES) ? NUM_HASHES : MAX_LANES;
	localparam int MW0   = (PRIMARY_WIDTH > SECONDARY_WIDTH) ? PRIMARY_WIDTH : SECONDARY_WIDTH;
	localparam int AW    = ((MW0 > EST_W) ? MW0 : EST_W) + 1;
	localparam logic [PRIMARY_WIDTH-1:0]   PMAX = '1;
	localparam logic [SECONDARY_WIDTH-1:0] SMAX = '1;
	localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(LANES - 1);
	localparam logic [AW-1:0] SMAX_W = AW'(SMAX);
	localparam logic [AW-1:0] EMAX_W = AW'({EST_W{1'b1}});

	op_t                        op_q;
	logic [PRI_AW-1:0]          pidx_q [MAX_LANES];
	logic [SEC_AW-1:0]          sidx_q [MAX_LANES];
	logic [LANE_W-1:0]          lane_q;
	logic [PRI_AW-1:0]          clr_q;
	logic [PRIMARY_WIDTH-1:0]   pmin_q;
	logic [HITS_W-1:0]          phits_q;
	logic [SECONDARY_WIDTH-1:0] smin_q;
	logic [PRIMARY_WIDTH-1:0]   p_rdata_q;
	logic [SECONDARY_WIDTH-1:0] s_rdata_q;
	logic [EST_W-1:0]           estimate_q;
	logic                       single_q;

	logic [PRIMARY_WIDTH-1:0]   pmem [PRI_CELLS];
	logic [SECONDARY_WIDTH-1:0] smem [SEC_CELLS];

	logic [PRI_AW-1:0]          p_addr;
	logic [SEC_AW-1:0]          s_addr;
	logic [PRIMARY_WIDTH-1:0]   p_wdata;
	logic [SECONDARY_WIDTH-1:0] s_wdata;
	logic [AW-1:0]              s_sum;
	logic [AW-1:0]              est_w;
	logic                       single;
	logic                       smin_nz;

	assign single  = (phits_q == HITS_W'(1));
	assign smin_nz = (smin_q != '0);

	assign p_addr = cmd.clr ? clr_q : pidx_q[lane_q];
	assign s_addr = cmd.clr ? clr_q[SEC_AW-1:0] : sidx_q[lane_q];

	always_comb begin
		if (cmd.clr) begin
			p_wdata = '0;
		end else if (op_q == OP_ADD) begin
			p_wdata = (p_rdata_q == PMAX) ? PMAX : p_rdata_q + 1'b1;
		end else begin
			p_wdata = (p_rdata_q == '0) ? '0 : p_rdata_q - 1'b1;
		end
	end

	// add step: 1 when secondary minimum nonzero, else the primary minimum
	always_comb begin
		s_sum = AW'(s_rdata_q) + (smin_nz ? AW'(1) : AW'(pmin_q));
		if (cmd.clr) begin
			s_wdata = '0;
		end else if (op_q == OP_ADD) begin
			s_wdata = (s_sum > SMAX_W) ? SMAX : s_sum[SECONDARY_WIDTH-1:0];
		end else begin
			s_wdata = (s_rdata_q == '0) ? '0 : s_rdata_q - 1'b1;
		end
	end

	always_comb begin
		est_w = (single && smin_nz) ? AW'(smin_q) : AW'(pmin_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.p_we) begin
			pmem[p_addr] <= p_wdata;
		end
		if (cmd.p_re) begin
			p_rdata_q <= pmem[p_addr];
		end
		if (cmd.s_we) begin
			smem[s_addr] <= s_wdata;
		end
		if (cmd.s_re) begin
			s_rdata_q <= smem[s_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= OP_ADD;
			lane_q <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.load) begin
				op_q <= op_t'(op);
			end
			if (cmd.lane_rst) begin
				lane_q <= '0;
			end else if (cmd.lane_inc) begin
				lane_q <= lane_q + 1'b1;
			end
			if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pidx_q[0] <= primary_index_0;
			pidx_q[1] <= primary_index_1;
			pidx_q[2] <= primary_index_2;
			pidx_q[3] <= primary_index_3;
			sidx_q[0] <= secondary_index_0;
			sidx_q[1] <= secondary_index_1;
			sidx_q[2] <= secondary_index_2;
			sidx_q[3] <= secondary_index_3;
			phits_q   <= '0;
		end
		if (cmd.p_acc) begin
			if (lane_q == '0 || p_rdata_q < pmin_q) begin
				pmin_q  <= p_rdata_q;
				phits_q <= HITS_W'(1);
			end else if (p_rdata_q == pmin_q) begin
				phits_q <= phits_q + 1'b1;
			end
		end
		if (cmd.load) begin
			smin_q <= '0;
		end else if (cmd.s_acc) begin
			if (lane_q == '0 || s_rdata_q < smin_q) begin
				smin_q <= s_rdata_q;
			end
		end
		if (cmd.out_load) begin
			if (op_q == OP_LOOKUP) begin
				estimate_q <= (est_w > EMAX_W) ? {EST_W{1'b1}} : est_w[EST_W-1:0];
			end else begin
				estimate_q <= '0;
			end
			single_q <= (op_q != OP_CLEAR) && single;
		end
	end

	assign sts.op        = op_q;
	assign sts.lane_last = (lane_q == LAST_LANE);
	assign sts.clr_last  = (clr_q == PRI_AW'(PRI_CELLS - 1));
	assign sts.single    = single;
	assign sts.smin_nz   = smin_nz;

	assign estimate       = estimate_q;
	assign single_minimum = single_q;

endmodule

// ===== design/sbrm_ctrl.sv =====
// controller: sequences clearing sweep, counter updates and minimum scans
// depends on sbrm_pkg
module sbrm_ctrl import sbrm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd,
	input  sts_t sts
);

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_CLR   = 12'b0000_0000_0010,
		ST_P_RD  = 12'b0000_0000_0100,
		ST_P_WR  = 12'b0000_0000_1000,
		ST_PM_RD = 12'b0000_0001_0000,
		ST_PM_AC = 12'b0000_0010_0000,
		ST_P_CHK = 12'b0000_0100_0000,
		ST_S_RD  = 12'b0000_1000_0000,
		ST_S_AC  = 12'b0001_0000_0000,
		ST_S_CHK = 12'b0010_0000_0000,
		ST_SU_RD = 12'b0100_0000_0000,
		ST_SU_WR = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   fin_q, fin_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall  = (state_q != ST_IDLE) || fin_q;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		fin_d   = fin_q;
		cmd     = '0;
		if (fin_q) begin
			if (out_free) begin
				cmd.out_load = 1'b1;
				fin_d        = 1'b0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd.load     = 1'b1;
						cmd.lane_rst = 1'b1;
						state_d      = ST_P_RD;
					end
				end
				ST_CLR: begin
					cmd.clr  = 1'b1;
					cmd.p_we = 1'b1;
					cmd.s_we = 1'b1;
					if (sts.clr_last) begin
						state_d = ST_IDLE;
						fin_d   = (sts.op == OP_CLEAR);
					end
				end
				ST_P_RD: begin
					// dispatch on the captured op
					unique case (sts.op)
						OP_CLEAR: begin
							state_d = ST_CLR;
						end
						OP_LOOKUP: begin
							state_d = ST_PM_RD;
						end
						default: begin
							cmd.p_re = 1'b1;
							state_d  = ST_P_WR;
						end
					endcase
				end
				ST_P_WR: begin
					cmd.p_we = 1'b1;
					if (sts.lane_last) begin
						cmd.lane_rst = 1'b1;
						state_d      = ST_PM_RD;
					end else begin
						cmd.lane_inc = 1'b1;
						state_d      = ST_P_RD;
					end
				end
				ST_PM_RD: begin
					cmd.p_re = 1'b1;
					state_d  = ST_PM_AC;
				end
				ST_PM_AC: begin
					cmd.p_acc = 1'b1;
					if (sts.lane_last) begin
						cmd.lane_rst = 1'b1;
						state_d      = ST_P_CHK;
					end else begin
						cmd.lane_inc = 1'b1;
						state_d      = ST_PM_RD;
					end
				end
				ST_P_CHK: begin
					state_d = sts.single ? ST_S_RD : ST_IDLE;
					fin_d   = !sts.single;
				end
				ST_S_RD: begin
					cmd.s_re = 1'b1;
					state_d  = ST_S_AC;
				end
				ST_S_AC: begin
					cmd.s_acc = 1'b1;
					if (sts.lane_last) begin
						cmd.lane_rst = 1'b1;
						state_d      = ST_S_CHK;
					end else begin
						cmd.lane_inc = 1'b1;
						state_d      = ST_S_RD;
					end
				end
				ST_S_CHK: begin
					if (sts.op == OP_ADD || (sts.op == OP_REMOVE && sts.smin_nz)) begin
						state_d = ST_SU_RD;
					end else begin
						state_d = ST_IDLE;
						fin_d   = 1'b1;
					end
				end
				ST_SU_RD: begin
					cmd.s_re = 1'b1;
					state_d  = ST_SU_WR;
				end
				ST_SU_WR: begin
					cmd.s_we = 1'b1;
					if (sts.lane_last) begin
						state_d = ST_IDLE;
						fin_d   = 1'b1;
					end else begin
						cmd.lane_inc = 1'b1;
						state_d      = ST_SU_RD;
					end
				end
				default: begin
					state_d = ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fin_q   <= fin_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != ST_IDLE))
		else $error("accepted request did not start work");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_q && out_valid_q && out_stall) |=> fin_q)
		else $error("result dropped while output stalled");
	a_sec_update_single: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SU_RD) |-> sts.single)
		else $error("secondary update without single minimum");
`endif

endmodule

// ===== design/spectral_bloom_recurring_minimum_top.sv =====
// spectral bloom filter with recurring-minimum estimate, top level
// depends on sbrm_pkg, sbrm_ctrl and sbrm_dp
//
// usage
//   input channel: in_valid / in_stall with op and four primary and four secondary
//   indices; a request is taken when in_valid is high and in_stall low
//   output channel: out_valid / out_stall with estimate and single_minimum, one
//   result per request, in request order
//   add and remove read-modify-write each primary counter, rescan the primary counters,
//   then on a single minimum scan and possibly update the secondary counters, one
//   index after another; lookup only runs the scans
//   the single-port counter memories bound the rate: one access per cycle each
//   clear sweeps both tables and writes zero to every cell
//   after reset the same clearing sweep runs with in_stall high
//   the result register lets one finished result wait under out_stall; the next
//   request's work then runs and holds at its end until the register frees up
module spectral_bloom_recurring_minimum_top import sbrm_pkg::*; #(
	parameter int PRIMARY_WIDTH   = DEF_PRIMARY_WIDTH,
	parameter int SECONDARY_WIDTH = DEF_SECONDARY_WIDTH,
	parameter int NUM_HASHES      = DEF_NUM_HASHES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        op,
	input  logic [PRI_AW-1:0] primary_index_0,
	input  logic [PRI_AW-1:0] primary_index_1,
	input  logic [PRI_AW-1:0] primary_index_2,
	input  logic [PRI_AW-1:0] primary_index_3,
	input  logic [SEC_AW-1:0] secondary_index_0,
	input  logic [SEC_AW-1:0] secondary_index_1,
	input  logic [SEC_AW-1:0] secondary_index_2,
	input  logic [SEC_AW-1:0] secondary_index_3,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [EST_W-1:0]  estimate,
	output logic              single_minimum
);

	cmd_t cmd;
	sts_t sts;

	// sequencing of memory passes
	sbrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// counter tables and minimum tracking
	sbrm_dp #(
		.PRIMARY_WIDTH   (PRIMARY_WIDTH),
		.SECONDARY_WIDTH (SECONDARY_WIDTH),
		.NUM_HASHES      (NUM_HASHES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.op                (op),
		.primary_index_0   (primary_index_0),
		.primary_index_1   (primary_index_1),
		.primary_index_2   (primary_index_2),
		.primary_index_3   (primary_index_3),
		.secondary_index_0 (secondary_index_0),
		.secondary_index_1 (secondary_index_1),
		.secondary_index_2 (secondary_index_2),
		.secondary_index_3 (secondary_index_3),
		.estimate          (estimate),
		.single_minimum    (single_minimum)
	);

endmodule
